/* rtl/t9lpm_pkg.sv */
// ----------------------------------------------------------------------------
// T9 line pattern matcher - shared package
// Keypad class table, configuration register indexes and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package t9lpm_pkg;

    localparam int MAX_PATTERN_DEF = 16;

    // Fixed field widths
    localparam int CHAR_W    = 8;
    localparam int DIGITS_W  = 64;
    localparam int LEN_W     = 5;
    localparam int MODE_W    = 2;
    localparam int COL_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_DIGITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS     = 2'd3;

    // Search modes
    localparam logic [MODE_W-1:0] MODE_ALL       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUBSEQ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUBSTRING = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic cap;        // capture item payload
        logic col_start;  // open a column pass: row 0 to zero, seed diagonal
        logic col_empty;  // edit mode with an empty pattern
        logic col_step;   // update one column cell
        logic seq_step;   // subsequence update
        logic line_end;   // load result, clear line state
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              m_zero;
        logic              cell_last;
        logic              last;
        logic              out_free;
    } t_dp_stat;

    // Keypad class membership of a folded character
    function automatic logic key_match(input logic [CHAR_W-1:0] ch, input logic [3:0] digit);
        logic hit;
        hit = 1'b0;
        case (digit)
            4'd0: hit = (ch == 8'h30) || (ch == 8'h2B);
            4'd1: hit = (ch == 8'h31);
            4'd2: hit = (ch == 8'h32) || ((ch >= 8'h61) && (ch <= 8'h63));
            4'd3: hit = (ch == 8'h33) || ((ch >= 8'h64) && (ch <= 8'h66));
            4'd4: hit = (ch == 8'h34) || ((ch >= 8'h67) && (ch <= 8'h69));
            4'd5: hit = (ch == 8'h35) || ((ch >= 8'h6A) && (ch <= 8'h6C));
            4'd6: hit = (ch == 8'h36) || ((ch >= 8'h6D) && (ch <= 8'h6F));
            4'd7: hit = (ch == 8'h37) || ((ch >= 8'h70) && (ch <= 8'h73));
            4'd8: hit = (ch == 8'h38) || ((ch >= 8'h74) && (ch <= 8'h76));
            4'd9: hit = (ch == 8'h39) || ((ch >= 8'h77) && (ch <= 8'h7A));
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

/* rtl/t9lpm_ctrl.sv */
// ----------------------------------------------------------------------------
// T9 line pattern matcher - controller
// Sequences one item: capture, column pass, subsequence update, result.
// ----------------------------------------------------------------------------
`default_nettype none

module t9lpm_ctrl import t9lpm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CELL = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.cap = 1'b1;
                    if (i_stat.mode == MODE_SUBSTRING && !i_stat.m_zero) begin
                        o_cmd.col_start = 1'b1;
                        n_state         = S_CELL;
                    end else begin
                        o_cmd.col_empty = (i_stat.mode == MODE_SUBSTRING);
                        n_state         = S_FIN;
                    end
                end
            end
            S_CELL: begin
                o_cmd.col_step = 1'b1;
                if (i_stat.cell_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.seq_step = (i_stat.mode == MODE_SUBSEQ);
                n_state        = i_stat.last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.line_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/t9lpm_datapath.sv */
// ----------------------------------------------------------------------------
// T9 line pattern matcher - datapath
// Configuration registers, edit-distance column with one shared cell,
// subsequence pointer, found flag and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module t9lpm_datapath import t9lpm_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIGITS_W-1:0]  i_cfg_wdata,
    input  wire logic [CHAR_W-1:0]    i_line_char,
    input  wire logic                 i_last_char,
    input  wire logic                 i_out_ready,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic                      o_out_valid,
    output logic                      o_line_matches
);

    localparam int                CW     = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0]  MaxLen = LEN_W'(MAX_PATTERN);

    // Configuration
    logic [DIGITS_W-1:0] r_pattern;
    logic [LEN_W-1:0]    r_len;
    logic [MODE_W-1:0]   r_mode;
    logic [COL_W-1:0]    r_max;

    // Item payload
    logic [CHAR_W-1:0]   r_ch;
    logic                r_last;

    // Line state
    logic [COL_W-1:0]    r_col [MAX_PATTERN+1];
    logic [COL_W-1:0]    r_diag;
    logic [COL_W-1:0]    r_left;
    logic [CW-1:0]       r_j;
    logic [CW-1:0]       r_pos;
    logic                r_found;

    // Result
    logic                r_ov;
    logic                r_match;

    logic [LEN_W-1:0]    w_len_cl;
    logic [CW-1:0]       w_m;
    logic [CHAR_W-1:0]   w_fold;
    logic [COL_W-1:0]    w_above;
    logic [3:0]          w_didx;
    logic [3:0]          w_digit;
    logic                w_cost;
    logic [COL_W:0]      w_s1, w_s2, w_s3, w_min12, w_min;
    logic [COL_W-1:0]    w_cell;
    logic [3:0]          w_pidx;
    logic [3:0]          w_pdig;
    logic                w_pos_adv;
    logic [CW-1:0]       w_pos_next;
    logic                w_match;
    logic                w_out_free;

    assign w_len_cl = (r_len > MaxLen) ? MaxLen : r_len;
    assign w_m      = CW'(w_len_cl);

    // Upper case folds to lower case on capture
    assign w_fold = ((i_line_char >= 8'h41) && (i_line_char <= 8'h5A)) ?
                    (i_line_char + 8'h20) : i_line_char;

    // Shared column cell for row r_j
    assign w_above = r_col[r_j];
    assign w_didx  = 4'(5'(r_j) - 5'd1);
    assign w_digit = r_pattern[{w_didx, 2'b00} +: 4];
    assign w_cost  = !key_match(r_ch, w_digit);
    assign w_s1    = {1'b0, r_left} + 6'd1;
    assign w_s2    = {1'b0, w_above} + 6'd1;
    assign w_s3    = {1'b0, r_diag} + {5'd0, w_cost};
    assign w_min12 = (w_s1 < w_s2) ? w_s1 : w_s2;
    assign w_min   = (w_min12 < w_s3) ? w_min12 : w_s3;
    assign w_cell  = w_min[COL_W] ? {COL_W{1'b1}} : w_min[COL_W-1:0];

    // Subsequence pointer
    assign w_pidx     = 4'(5'(r_pos));
    assign w_pdig     = r_pattern[{w_pidx, 2'b00} +: 4];
    assign w_pos_adv  = (r_pos < w_m) && key_match(r_ch, w_pdig);
    assign w_pos_next = w_pos_adv ? (r_pos + CW'(1)) : r_pos;

    assign w_match    = ((r_mode == MODE_SUBSEQ) || (r_mode == MODE_SUBSTRING)) ?
                        ((w_m == '0) || r_found) : 1'b1;
    assign w_out_free = !r_ov || i_out_ready;

    assign o_stat.mode      = r_mode;
    assign o_stat.m_zero    = (w_m == '0);
    assign o_stat.cell_last = (r_j == w_m);
    assign o_stat.last      = r_last;
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid    = r_ov;
    assign o_line_matches = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= '0;
            r_mode    <= MODE_ALL;
            r_max     <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_PATTERN_DIGITS: r_pattern <= i_cfg_wdata;
                CFG_PATTERN_LENGTH: r_len     <= i_cfg_wdata[LEN_W-1:0];
                CFG_SEARCH_MODE:    r_mode    <= i_cfg_wdata[MODE_W-1:0];
                CFG_MAX_ERRORS:     r_max     <= i_cfg_wdata[COL_W-1:0];
                default:            r_max     <= r_max;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_ch   <= w_fold;
            r_last <= i_last_char;
        end
        if (i_cmd.col_start) begin
            r_diag <= r_col[0];
            r_left <= '0;
        end else if (i_cmd.col_step) begin
            r_diag <= w_above;
            r_left <= w_cell;
        end
        if (i_cmd.line_end) begin
            r_match <= w_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAX_PATTERN; k++) begin
                r_col[k] <= COL_W'(k);
            end
            r_j     <= '0;
            r_pos   <= '0;
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // a new result may replace the one taken at this edge
            if (i_cmd.line_end) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.col_start) begin
                r_col[0] <= '0;
                r_j      <= CW'(1);
            end
            if (i_cmd.col_empty) begin
                r_col[0] <= '0;
                r_found  <= 1'b1;
            end
            if (i_cmd.col_step) begin
                r_col[r_j] <= w_cell;
                r_j        <= r_j + CW'(1);
                if ((r_j == w_m) && (w_cell <= r_max)) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.seq_step) begin
                r_pos <= w_pos_next;
                if (w_pos_next >= w_m) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.line_end) begin
                for (int k = 0; k <= MAX_PATTERN; k++) begin
                    r_col[k] <= COL_W'(k);
                end
                r_pos   <= '0;
                r_found <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/t9_line_pattern_matcher_top.sv */
// ----------------------------------------------------------------------------
// T9 line pattern matcher - top level
// Matches text lines against a keypad digit pattern, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one character of a line
//    and a flag marking the final character. Upper case is folded to lower.
//  - Output channel (o_out_valid / i_out_ready) carries one match flag per
//    line, produced for the item that ends the line; other items give none.
//  - Configuration is a plain write port (i_cfg_wen, i_cfg_index,
//    i_cfg_wdata): 0 pattern digits, 1 pattern length, 2 mode, 3 edit limit.
//    Write only while no item is in flight.
//  - Timing: one item at a time. In edit-distance mode the single shared
//    cell walks the column one row a cycle. An item ending a line then
//    passes through the result state, which loads the result register.
//  - The result sits in an output register; the block takes further items
//    while it waits. If a second line finishes before the first result is
//    taken, the block holds in its result state until the receiver drains.
//  - Synchronous active-low reset clears configuration to zero, the column
//    to its initial ramp, the line state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module t9_line_pattern_matcher_top import t9lpm_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIGITS_W-1:0]  i_cfg_wdata,
    // character items
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [CHAR_W-1:0]    i_line_char,
    input  wire logic                 i_last_char,
    // line results
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_line_matches
);

    t_dp_cmd  w_cmd;   // controller to datapath
    t_dp_stat w_stat;  // datapath to controller

    t9lpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    t9lpm_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_line_char    (i_line_char),
        .i_last_char    (i_last_char),
        .i_out_ready    (i_out_ready),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .o_line_matches (o_line_matches)
    );

endmodule

`default_nettype wire

/* rtl/t9lpm_checker.sv */
// ----------------------------------------------------------------------------
// T9 line pattern matcher - port checker
// Watches the item channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module t9lpm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_line_matches
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_line_matches))
        else $error("result dropped or changed while stalled");

    // One item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while previous item still in work");

    // A new result is only loaded from the result state
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a finished line");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind t9_line_pattern_matcher_top t9lpm_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_line_matches (o_line_matches)
);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// T9 line pattern matcher - self-checking testbench
// Streams text lines through the matcher under many register settings and
// compares every line result against an in-bench keypad match predictor.
// ----------------------------------------------------------------------------

module tb_top;
    import t9lpm_pkg::*;

    // Cycles left after the last result before registers may be rewritten:
    // an unfinished line can still be walking the column.
    localparam int SETTLE_CYCLES  = MAX_PATTERN_DEF + 8;
    // Cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // Characters of random stimulus
    localparam int RANDOM_CHARS   = 850;
    // The package names modes 0..2 only; 3 is the spare encoding
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              hold;    // wait until all line results are in
    } t_char_item;

    // ------------------------------------------------------------------
    // DUT signals, inputs all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIGITS_W-1:0]  i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [CHAR_W-1:0]    i_line_char = '0;
    logic                 i_last_char = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_line_matches;

    t9_line_pattern_matcher_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_line_char    (i_line_char),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_line_matches (o_line_matches)
    );

    // 8 time unit period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: own copy of the registers and the line state
    // ------------------------------------------------------------------
    logic [DIGITS_W-1:0] pat_digits;
    logic [LEN_W-1:0]    pat_len;
    logic [MODE_W-1:0]   srch_mode;
    logic [LEN_W-1:0]    edit_limit;
    logic [COL_W-1:0]    dist_col [0:MAX_PATTERN_DEF];
    logic [LEN_W-1:0]    seq_pos;
    logic                found;

    // Traffic and bookkeeping
    t_char_item char_q[$];          // items waiting for the driver
    logic       match_exp_q[$];     // predicted line results, oldest first
    t_char_item next_item;
    int         pending_chars = 0;  // queued but not yet accepted
    int         in_gap        = 0;
    int         out_gap       = 0;
    bit         no_idle_in    = 1'b0;
    bit         no_idle_out   = 1'b0;
    bit         rst_done      = 1'b0;
    bit         in_fire       = 1'b0;
    int         idle_cycles   = 0;
    int         errors        = 0;
    int         queued_chars  = 0;
    int         queued_lines  = 0;
    int         settings      = 0;
    int         results_hit   = 0;
    int         results_miss  = 0;
    bit         line_open     = 1'b0;

    string key_chars =
        "0123456789+abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

    // ------------------------------------------------------------------
    // Keypad classes and the per-character predictor
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        if (c >= "A" && c <= "Z")
            return c + 8'd32;
        return c;
    endfunction

    // Digit key itself, '+' on key 0, and the letter run of keys 2..9
    function automatic logic keypad_hit(input logic [CHAR_W-1:0] ch, input logic [3:0] digit);
        logic [CHAR_W-1:0] first;
        int                span;
        first = 8'h00;
        span  = 0;
        if (digit > 4'd9)
            return 1'b0;
        if (ch == 8'("0" + digit))
            return 1'b1;
        case (digit)
            4'd0: return ch == "+";
            4'd2: begin first = "a"; span = 3; end
            4'd3: begin first = "d"; span = 3; end
            4'd4: begin first = "g"; span = 3; end
            4'd5: begin first = "j"; span = 3; end
            4'd6: begin first = "m"; span = 3; end
            4'd7: begin first = "p"; span = 4; end
            4'd8: begin first = "t"; span = 3; end
            4'd9: begin first = "w"; span = 4; end
            default: span = 0;
        endcase
        return (span != 0) && (ch >= first) && (int'(ch) < int'(first) + span);
    endfunction

    function automatic logic [3:0] digit_at(input int pos);
        return pat_digits[(pos % 16) * 4 +: 4];
    endfunction

    function automatic int used_len();
        return (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
    endfunction

    function automatic void clear_line();
        int j;
        for (j = 0; j <= MAX_PATTERN_DEF; j++)
            dist_col[j] = COL_W'(j);
        seq_pos = '0;
        found   = 1'b0;
    endfunction

    // One accepted character: update line state, queue a result on line end
    function automatic void predict_char(input logic [CHAR_W-1:0] raw, input logic last);
        logic [CHAR_W-1:0] ch;
        int m, j, diag, above, v, cost;
        ch = fold_case(raw);
        m  = used_len();
        if (srch_mode == MODE_SUBSEQ) begin
            if (seq_pos < m && keypad_hit(ch, digit_at(int'(seq_pos))))
                seq_pos = seq_pos + 1'b1;
            if (seq_pos >= m)
                found = 1'b1;
        end else if (srch_mode == MODE_SUBSTRING) begin
            // approximate substring: row 0 is free to start anywhere
            diag        = int'(dist_col[0]);
            dist_col[0] = '0;
            for (j = 1; j <= m; j++) begin
                above = int'(dist_col[j]);
                cost  = keypad_hit(ch, digit_at(j - 1)) ? 0 : 1;
                v     = int'(dist_col[j - 1]) + 1;
                if (above + 1 < v)
                    v = above + 1;
                if (diag + cost < v)
                    v = diag + cost;
                dist_col[j] = (v > 31) ? 5'd31 : COL_W'(v);
                diag = above;
            end
            if (dist_col[m] <= edit_limit)
                found = 1'b1;
        end
        if (!last)
            return;
        if (srch_mode == MODE_SUBSEQ || srch_mode == MODE_SUBSTRING)
            match_exp_q.push_back((m == 0) ? 1'b1 : found);
        else
            match_exp_q.push_back(1'b1);
        clear_line();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIGITS_W-1:0] val);
        case (idx)
            CFG_PATTERN_DIGITS: pat_digits = val;
            CFG_PATTERN_LENGTH: pat_len    = val[LEN_W-1:0];
            CFG_SEARCH_MODE:    srch_mode  = val[MODE_W-1:0];
            CFG_MAX_ERRORS:     edit_limit = val[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Mostly back-to-back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_W-1:0] filler_char();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 99) < 35)
            c = 8'($urandom_range(0, 255));
        else
            c = key_chars[$urandom_range(0, key_chars.len() - 1)];
        return c;
    endfunction

    // A random character of the digit's class, either case; a random byte for codes above nine
    function automatic logic [CHAR_W-1:0] char_of_digit(input logic [3:0] digit);
        logic [CHAR_W-1:0] c;
        if (digit > 4'd9) begin
            c = 8'($urandom_range(0, 255));
            return c;
        end
        do
            c = key_chars[$urandom_range(0, key_chars.len() - 1)];
        while (!keypad_hit(fold_case(c), digit));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: changes at the falling edge, only after acceptance
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (!i_in_valid || in_fire) begin
                if (in_gap > 0) begin
                    i_in_valid <= 1'b0;
                    in_gap--;
                end else if (char_q.size() != 0 &&
                             !(char_q[0].hold && match_exp_q.size() != 0)) begin
                    next_item   = char_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_line_char <= next_item.ch;
                    i_last_char <= next_item.last;
                    in_gap      = no_idle_in ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            // receiver: one ready cycle, then a random stall; always ready in no-idle runs
            if (no_idle_out || out_gap == 0) begin
                i_out_ready <= 1'b1;
                out_gap     = no_idle_out ? 0 : pick_gap();
            end else begin
                i_out_ready <= 1'b0;
                out_gap--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge
    // Results are checked before the predictor runs, so a result taken
    // at the same edge as a line end is never paired with that line.
    // ------------------------------------------------------------------
    logic exp_match;

    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (match_exp_q.size() == 0) begin
                    errors++;
                    $display("%0t: line result %0b with none expected", $time, o_line_matches);
                end else begin
                    exp_match = match_exp_q.pop_front();
                    if (o_line_matches !== exp_match) begin
                        errors++;
                        $display("%0t: line_matches expected %0b actual %0b",
                                 $time, exp_match, o_line_matches);
                    end
                    if (exp_match) results_hit++;
                    else results_miss++;
                end
            end
            if (in_fire) begin
                predict_char(i_line_char, i_last_char);
                pending_chars--;
            end
            if (in_fire || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Hang detection
    always @(negedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, match_exp_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DIGITS_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        apply_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    task automatic set_regs(input logic [DIGITS_W-1:0] digits, input logic [DIGITS_W-1:0] len,
                            input logic [DIGITS_W-1:0] mode, input logic [DIGITS_W-1:0] errs);
        write_reg(CFG_PATTERN_DIGITS, digits);
        write_reg(CFG_PATTERN_LENGTH, len);
        write_reg(CFG_SEARCH_MODE, mode);
        write_reg(CFG_MAX_ERRORS, errs);
        settings++;
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last, input logic hold);
        t_char_item it;
        it.ch   = ch;
        it.last = last;
        it.hold = hold;
        char_q.push_back(it);
        pending_chars++;
        queued_chars++;
        if (last) queued_lines++;
        line_open = !last;
    endtask

    // Wait for all results, then give a column walk time to finish
    task automatic settle();
        do @(negedge i_clk);
        while (pending_chars != 0 || match_exp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Small registers sometimes carry junk above their width
    function automatic logic [DIGITS_W-1:0] with_junk(input int val, input int width);
        logic [DIGITS_W-1:0] w;
        w = DIGITS_W'(val);
        if ($urandom_range(0, 9) == 0)
            w = w | ({$urandom, $urandom} << width);
        return w;
    endfunction

    task automatic randomise_regs();
        logic [DIGITS_W-1:0] digits;
        int r, k, len, mode, errs;
        r = $urandom_range(0, 99);
        if (r < 3)
            digits = '0;
        else if (r < 6)
            digits = '1;
        else begin
            for (k = 0; k < 16; k++)
                digits[k*4 +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                                : 4'($urandom_range(0, 9));
        end
        // short patterns keep the column walk quick
        r = $urandom_range(0, 99);
        if (r < 5)       len = 0;
        else if (r < 12) len = $urandom_range(17, 31);
        else if (r < 27) len = $urandom_range(9, 16);
        else             len = $urandom_range(1, 8);
        r = $urandom_range(0, 99);
        if (r < 10)      mode = int'(MODE_ALL);
        else if (r < 45) mode = int'(MODE_SUBSEQ);
        else if (r < 90) mode = int'(MODE_SUBSTRING);
        else             mode = int'(MODE_SPARE);
        r = $urandom_range(0, 99);
        if (r < 50)      errs = 0;
        else if (r < 80) errs = $urandom_range(1, 3);
        else if (r < 95) errs = $urandom_range(4, 16);
        else             errs = $urandom_range(17, 31);
        set_regs(digits, with_junk(len, LEN_W), with_junk(mode, MODE_W),
                 with_junk(errs, LEN_W));
    endtask

    // Mostly the pattern spelt out with a few edits, else plain noise
    task automatic queue_random_line(input bit finish);
        logic [CHAR_W-1:0] line[$];
        int m, k, e, n;
        bit hold;
        m = used_len();
        if (m > 0 && $urandom_range(0, 99) < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
            repeat (n) line.push_back(filler_char());
            for (k = 0; k < m; k++) begin
                e = $urandom_range(0, 99);
                if (srch_mode == MODE_SUBSEQ && e >= 75)
                    line.push_back(filler_char());
                if (e < 6)
                    line.push_back(filler_char());           // substitution
                else if (e < 10)
                    ;                                         // deletion
                else if (e < 14) begin
                    line.push_back(char_of_digit(digit_at(k)));
                    line.push_back(filler_char());           // insertion
                end else
                    line.push_back(char_of_digit(digit_at(k)));
            end
            n = $urandom_range(0, 3);
            repeat (n) line.push_back(filler_char());
        end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
            repeat (n) line.push_back(filler_char());
        end
        if (line.size() == 0)
            line.push_back(filler_char());
        hold = ($urandom_range(0, 99) < 4);
        for (k = 0; k < line.size(); k++)
            push_char(line[k], finish && (k == line.size() - 1), hold && (k == 0));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int start_chars, nlines, l;

        pat_digits = '0;
        pat_len    = '0;
        srch_mode  = MODE_ALL;
        edit_limit = '0;
        clear_line();

        // reset held from time zero, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // --- directed part ---
        // reset settings: every line matches; byte extremes
        push_char(8'h00, 1'b0, 1'b0);
        push_char(8'hFF, 1'b1, 1'b0);
        settle();

        // subsequence "23": upper case folds, order matters
        set_regs(64'h32, 64'd2, DIGITS_W'(MODE_SUBSEQ), 64'd0);
        push_char("A", 1'b0, 1'b0);
        push_char("x", 1'b0, 1'b0);
        push_char("D", 1'b1, 1'b0);
        push_char("3", 1'b0, 1'b0);
        push_char("2", 1'b1, 1'b0);
        settle();

        // exact substring "01": '+' on key 0, gap needs one edit
        set_regs(64'h10, 64'd2, DIGITS_W'(MODE_SUBSTRING), 64'd0);
        push_char("+", 1'b0, 1'b0);
        push_char("1", 1'b1, 1'b0);
        push_char("0", 1'b0, 1'b0);
        push_char("x", 1'b0, 1'b0);
        push_char("1", 1'b1, 1'b0);
        settle();

        // full-length pattern of dead digits: limit at and below the length
        set_regs('1, 64'd16, DIGITS_W'(MODE_SUBSTRING), 64'd16);
        push_char("z", 1'b1, 1'b0);
        settle();
        write_reg(CFG_MAX_ERRORS, 64'd15);
        push_char("z", 1'b1, 1'b0);
        settle();

        // spare mode behaves as match-all
        set_regs(64'h99, 64'd2, DIGITS_W'(MODE_SPARE), 64'd0);
        push_char("q", 1'b1, 1'b0);
        settle();

        // empty pattern in both search modes
        set_regs(64'h7, 64'd0, DIGITS_W'(MODE_SUBSEQ), 64'd0);
        push_char("k", 1'b1, 1'b0);
        settle();
        write_reg(CFG_SEARCH_MODE, DIGITS_W'(MODE_SUBSTRING));
        push_char("k", 1'b1, 1'b0);
        settle();

        // length beyond the maximum is clipped to sixteen
        set_regs(64'h2222_2222_2222_2222, 64'd31, DIGITS_W'(MODE_SUBSTRING), 64'd15);
        push_char("B", 1'b1, 1'b0);
        settle();

        // digit code above nine matches nothing; second item waits for drain
        set_regs(64'hA, 64'd1, DIGITS_W'(MODE_SUBSEQ), 64'd0);
        push_char("a", 1'b0, 1'b0);
        push_char("+", 1'b1, 1'b1);
        settle();

        // registers rewritten in mid-line: state so far carries over
        set_regs(64'h5, 64'd1, DIGITS_W'(MODE_SUBSEQ), 64'd0);
        push_char("j", 1'b0, 1'b0);
        settle();
        write_reg(CFG_PATTERN_DIGITS, 64'h65);
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        push_char("m", 1'b1, 1'b0);
        settle();

        // --- random part ---
        // each setting gets a burst of lines; the odd one is left open so
        // the next setting picks it up in mid-line
        start_chars = queued_chars;
        while (queued_chars - start_chars < RANDOM_CHARS) begin
            randomise_regs();
            no_idle_in  = ($urandom_range(0, 3) == 0);
            no_idle_out = ($urandom_range(0, 3) == 0);
            nlines = $urandom_range(3, 8);
            for (l = 0; l < nlines; l++)
                queue_random_line(!(l == nlines - 1 && $urandom_range(0, 6) == 0));
            settle();
        end
        if (line_open) begin
            push_char(filler_char(), 1'b1, 1'b0);
            settle();
        end

        $display("Covered %0d characters in %0d lines under %0d register settings",
                 queued_chars, queued_lines, settings);
        $display("Line results checked: %0d matching, %0d not matching",
                 results_hit, results_miss);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/t9lpm_pkg.sv
rtl/t9lpm_ctrl.sv
rtl/t9lpm_datapath.sv
rtl/t9_line_pattern_matcher_top.sv
rtl/t9lpm_checker.sv
tb/tb_top.sv
